[rtl/boot_keyboard_report_to_key_events_unit_macros.svh]
// assertion macros for the boot keyboard key event unit
// no dependencies; included by the top level, which checks its own logic
`ifndef BOOT_KEYBOARD_REPORT_TO_KEY_EVENTS_UNIT_MACROS_SVH
`define BOOT_KEYBOARD_REPORT_TO_KEY_EVENTS_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BKRE_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BKRE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BKRE_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg)

`define BKRE_ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/bkre_pkg.sv]
// shared types, constants and the keycode to ascii table
// no dependencies
package bkre_pkg;

   localparam int MAX_SLOTS   = 6;
   localparam int SLOT_IDX_W  = $clog2(MAX_SLOTS);
   localparam int MOD_BITS    = 8;
   localparam int MOD_IDX_W   = $clog2(MOD_BITS);
   localparam int CMDQ_DEPTH  = 2;
   localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

   localparam logic       ACTION_POP     = 1'b1;
   localparam logic [6:0] MIN_REPORT_LEN = 7'd8;
   localparam logic [7:0] MOD_CODE_BASE  = 8'hE0;
   localparam logic [7:0] SHIFT_MASK     = 8'h22;

   typedef struct packed {
      logic       action;
      logic [6:0] report_length;
      logic [7:0] modifier_bits;
      logic [7:0] key_slot_0;
      logic [7:0] key_slot_1;
      logic [7:0] key_slot_2;
      logic [7:0] key_slot_3;
      logic [7:0] key_slot_4;
      logic [7:0] key_slot_5;
   } req_payload_type;

   typedef struct packed {
      logic       event_valid;
      logic [7:0] key_code;
      logic [6:0] ascii_code;
      logic [7:0] event_modifiers;
      logic       key_pressed;
   } rsp_payload_type;

   typedef enum logic [0:0] {
      CMD_REPORT,
      CMD_POP
   } cmd_kind_type;

   // one classified item handed from front to back
   typedef struct packed {
      cmd_kind_type                    kind;
      logic [7:0]                      mods;
      logic [MOD_BITS-1:0]             mod_change;
      logic [MAX_SLOTS-1:0][7:0]       prev_slots;
      logic [MAX_SLOTS-1:0]            release_mask;
      logic [MAX_SLOTS-1:0][7:0]       cur_slots;
      logic [MAX_SLOTS-1:0]            press_mask;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } cmdq_status_type;

   typedef struct packed {
      logic [7:0] code;
      logic [6:0] ascii;
      logic [7:0] mods;
      logic       down;
   } ring_entry_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_EVENTS,
      BACK_POP_SEND
   } back_state_type;

   // boot keyboard usage to ascii, numpad rows follow their legends
   function automatic logic [6:0] ascii_lookup(input logic [7:0] code, input logic shift);
      logic [6:0] ch;
      ch = 7'd0;
      unique case (code) inside
         [8'h04:8'h1D]: ch = (shift ? 7'h41 : 7'h61) + 7'(code - 8'h04);
         8'h1E:         ch = shift ? 7'h21 : 7'h31;   // ! 1
         8'h1F:         ch = shift ? 7'h40 : 7'h32;   // @ 2
         8'h20:         ch = shift ? 7'h23 : 7'h33;   // # 3
         8'h21:         ch = shift ? 7'h24 : 7'h34;   // $ 4
         8'h22:         ch = shift ? 7'h25 : 7'h35;   // % 5
         8'h23:         ch = shift ? 7'h5E : 7'h36;   // ^ 6
         8'h24:         ch = shift ? 7'h26 : 7'h37;   // & 7
         8'h25:         ch = shift ? 7'h2A : 7'h38;   // * 8
         8'h26:         ch = shift ? 7'h28 : 7'h39;   // ( 9
         8'h27:         ch = shift ? 7'h29 : 7'h30;   // ) 0
         8'h28, 8'h58:  ch = 7'h0D;                   // enter
         8'h29:         ch = 7'h1B;                   // escape
         8'h2A:         ch = 7'h08;                   // backspace
         8'h2B:         ch = 7'h09;                   // tab
         8'h2C:         ch = 7'h20;                   // space
         8'h2D:         ch = shift ? 7'h5F : 7'h2D;   // _ -
         8'h2E:         ch = shift ? 7'h2B : 7'h3D;   // + =
         8'h2F:         ch = shift ? 7'h7B : 7'h5B;   // { [
         8'h30:         ch = shift ? 7'h7D : 7'h5D;   // } ]
         8'h31:         ch = shift ? 7'h7C : 7'h5C;   // | backslash
         8'h33:         ch = shift ? 7'h3A : 7'h3B;   // : ;
         8'h34:         ch = shift ? 7'h22 : 7'h27;   // double and single quote
         8'h35:         ch = shift ? 7'h7E : 7'h60;   // ~ grave
         8'h36:         ch = shift ? 7'h3C : 7'h2C;   // < ,
         8'h37:         ch = shift ? 7'h3E : 7'h2E;   // > .
         8'h38, 8'h54:  ch = 7'h2F;                   // ? on shift for main row
         8'h55:         ch = 7'h2A;                   // keypad *
         8'h56:         ch = 7'h2D;                   // keypad -
         8'h57:         ch = 7'h2B;                   // keypad +
         [8'h59:8'h61]: ch = 7'h31 + 7'(code - 8'h59);
         8'h62:         ch = 7'h30;                   // keypad 0
         8'h63:         ch = 7'h2E;                   // keypad .
         default:       ch = 7'd0;
      endcase
      // main row slash shifts to question mark, keypad slash never does
      if (code == 8'h38 && shift) begin
         ch = 7'h3F;
      end
      return ch;
   endfunction

endpackage

[rtl/bkre_stream_if.sv]
// valid/ready channel carrying one payload of a given type
// no dependencies; payload type comes from the instantiating level
interface bkre_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/bkre_front.sv]
// front end: accepts requests, drops short reports, diffs against the previous report
// depends on bkre_pkg and bkre_stream_if
module bkre_front import bkre_pkg::*; #(
   parameter int ROLLOVER_SLOTS = 6
) (
   input  logic              clock,
   input  logic              reset,
   bkre_stream_if.sink       req_chan,
   input  logic              cmd_ready,
   output logic              cmd_valid,
   output cmd_type           cmd
);

   logic [7:0]                last_mods_ff, last_mods_in;
   logic [MAX_SLOTS-1:0][7:0] last_slots_ff, last_slots_in;
   logic [MAX_SLOTS-1:0][7:0] in_slots;
   logic [MAX_SLOTS-1:0][7:0] cur_slots;
   logic [MAX_SLOTS-1:0]      held_now;
   logic [MAX_SLOTS-1:0]      held_before;
   logic                      accept;
   logic                      is_pop;
   logic                      report_ok;

   assign req_chan.ready = cmd_ready;
   assign accept         = req_chan.valid && cmd_ready;
   assign is_pop         = req_chan.payload.action == ACTION_POP;
   assign report_ok      = req_chan.payload.report_length >= MIN_REPORT_LEN;

   assign in_slots = {req_chan.payload.key_slot_5, req_chan.payload.key_slot_4,
                      req_chan.payload.key_slot_3, req_chan.payload.key_slot_2,
                      req_chan.payload.key_slot_1, req_chan.payload.key_slot_0};

   always_comb begin
      cur_slots   = '0;
      held_now    = '0;
      held_before = '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         if (i < ROLLOVER_SLOTS) begin
            cur_slots[i] = in_slots[i];
         end
      end
      // every slot checked on its own, duplicates give duplicate events
      for (int i = 0; i < MAX_SLOTS; i++) begin
         for (int j = 0; j < ROLLOVER_SLOTS; j++) begin
            if (cur_slots[j] == last_slots_ff[i]) begin
               held_now[i] = 1'b1;
            end
            if (last_slots_ff[j] == cur_slots[i]) begin
               held_before[i] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      cmd.kind       = is_pop ? CMD_POP : CMD_REPORT;
      cmd.mods       = req_chan.payload.modifier_bits;
      cmd.mod_change = req_chan.payload.modifier_bits ^ last_mods_ff;
      cmd.prev_slots = last_slots_ff;
      cmd.cur_slots  = cur_slots;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         cmd.release_mask[i] = (last_slots_ff[i] != 8'd0) && !held_now[i];
         cmd.press_mask[i]   = (cur_slots[i] != 8'd0) && !held_before[i];
      end
   end

   assign cmd_valid = accept && (is_pop || report_ok);

   always_comb begin
      last_mods_in  = last_mods_ff;
      last_slots_in = last_slots_ff;
      if (accept && !is_pop && report_ok) begin
         last_mods_in  = req_chan.payload.modifier_bits;
         last_slots_in = cur_slots;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_mods_ff  <= '0;
         last_slots_ff <= '0;
      end else begin
         last_mods_ff  <= last_mods_in;
         last_slots_ff <= last_slots_in;
      end
   end

endmodule

[rtl/bkre_cmd_queue.sv]
// two-entry command queue between front and back end
// depends on bkre_pkg
module bkre_cmd_queue import bkre_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   input  cmd_type         push_data,
   output logic            push_ready,
   output logic            head_valid,
   output cmd_type         head_data,
   input  logic            pop,
   output cmdq_status_type status
);

   cmd_type                 entries_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign status.empty = count_ff == '0;
   assign status.full  = count_ff == CMDQ_CNT_W'(CMDQ_DEPTH);
   assign push_ready   = !status.full;
   assign head_valid   = !status.empty;
   assign head_data    = entries_ff[rd_ptr_ff];

   assign do_push = push_valid && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + CMDQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + CMDQ_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CMDQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CMDQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/bkre_back.sv]
// back end: event sequencer, event ring and registered response
// depends on bkre_pkg and bkre_stream_if
module bkre_back import bkre_pkg::*; #(
   parameter int RING_DEPTH     = 32,
   parameter int ROLLOVER_SLOTS = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  cmd_type       head,
   output logic          deq,
   bkre_stream_if.source rsp_chan
);

   localparam int RING_W = $clog2(RING_DEPTH);
   localparam int STEPS  = MOD_BITS + 2 * ROLLOVER_SLOTS;
   localparam int STEP_W = $clog2(STEPS);

   back_state_type         state_ff, state_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [RING_W-1:0]      wr_ff, wr_in;
   logic [RING_W-1:0]      rd_ff, rd_in;
   ring_entry_type         ring_mem_ff [RING_DEPTH];
   ring_entry_type         rd_data_ff;
   logic                   pop_hit_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic                   start_pop;
   logic                   start_events;
   logic                   ring_we;
   logic                   rsp_load;
   logic                   rsp_free;
   logic                   last_step;
   logic                   ring_full;
   logic                   ring_nonempty;
   logic                   ev_hit;
   ring_entry_type         ev;
   logic [MOD_IDX_W-1:0]   mod_idx;
   logic [SLOT_IDX_W-1:0]  rel_idx;
   logic [SLOT_IDX_W-1:0]  prs_idx;

   function automatic logic [RING_W-1:0] ring_next(input logic [RING_W-1:0] i);
      return (i == RING_W'(RING_DEPTH - 1)) ? '0 : i + RING_W'(1);
   endfunction

   assign rsp_free      = !rsp_valid_ff || rsp_chan.ready;
   assign last_step     = step_ff == STEP_W'(STEPS - 1);
   assign ring_full     = ring_next(wr_ff) == rd_ff;
   assign ring_nonempty = rd_ff != wr_ff;

   // decode of the current step: modifiers, then releases, then presses
   always_comb begin
      mod_idx = step_ff[MOD_IDX_W-1:0];
      rel_idx = SLOT_IDX_W'(step_ff - STEP_W'(MOD_BITS));
      prs_idx = SLOT_IDX_W'(step_ff - STEP_W'(MOD_BITS + ROLLOVER_SLOTS));
      ev      = '0;
      ev_hit  = 1'b0;
      ev.mods = head.mods;
      if (step_ff < STEP_W'(MOD_BITS)) begin
         ev_hit  = head.mod_change[mod_idx];
         ev.code = MOD_CODE_BASE + 8'(mod_idx);
         ev.down = head.mods[mod_idx];
      end else if (step_ff < STEP_W'(MOD_BITS + ROLLOVER_SLOTS)) begin
         ev_hit  = head.release_mask[rel_idx];
         ev.code = head.prev_slots[rel_idx];
      end else begin
         ev_hit   = head.press_mask[prs_idx];
         ev.code  = head.cur_slots[prs_idx];
         ev.ascii = ascii_lookup(head.cur_slots[prs_idx], (head.mods & SHIFT_MASK) != 8'd0);
         ev.down  = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (head_valid) begin
               state_in = (head.kind == CMD_POP) ? BACK_POP_SEND : BACK_EVENTS;
            end
         end
         BACK_EVENTS: begin
            if (last_step) begin
               state_in = BACK_IDLE;
            end
         end
         BACK_POP_SEND: begin
            if (rsp_free) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      start_pop    = 1'b0;
      start_events = 1'b0;
      ring_we      = 1'b0;
      rsp_load     = 1'b0;
      deq          = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            start_pop    = head_valid && head.kind == CMD_POP;
            start_events = head_valid && head.kind == CMD_REPORT;
         end
         BACK_EVENTS: begin
            ring_we = ev_hit && !ring_full;
            deq     = last_step;
         end
         BACK_POP_SEND: begin
            rsp_load = rsp_free;
            deq      = rsp_free;
         end
         default: begin
            deq = 1'b0;
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (start_events) begin
         step_in = '0;
      end else if (state_ff == BACK_EVENTS) begin
         step_in = step_ff + STEP_W'(1);
      end
      wr_in = ring_we ? ring_next(wr_ff) : wr_ff;
      rd_in = (start_pop && ring_nonempty) ? ring_next(rd_ff) : rd_ff;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // an empty pop returns all zero fields
      rsp_data_in = '0;
      if (pop_hit_ff) begin
         rsp_data_in.event_valid     = 1'b1;
         rsp_data_in.key_code        = rd_data_ff.code;
         rsp_data_in.ascii_code      = rd_data_ff.ascii;
         rsp_data_in.event_modifiers = rd_data_ff.mods;
         rsp_data_in.key_pressed     = rd_data_ff.down;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         step_ff      <= '0;
         wr_ff        <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem_ff[wr_ff] <= ev;
      end
   end

   always_ff @(posedge clock) begin
      if (start_pop) begin
         rd_data_ff <= ring_mem_ff[rd_ff];
         pop_hit_ff <= ring_nonempty;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

[rtl/boot_keyboard_report_to_key_events_unit.sv]
// top level of the boot keyboard report to key event unit
// depends on bkre_pkg, bkre_stream_if, bkre_front, bkre_cmd_queue, bkre_back and the macro header
`include "boot_keyboard_report_to_key_events_unit_macros.svh"

// Takes boot keyboard requests on req_chan: a report (action 0) is diffed
// against the previous report and turned into key events, a pop (action 1)
// returns one event on rsp_chan, or event_valid 0 when the ring is empty.
// Reports shorter than 8 bytes are dropped without touching any state.
// Events are ordered modifier changes (0xE0..0xE7, bit 0 first), releases
// in previous-slot order, then presses in current-slot order with their
// ascii code (shifted when left or right shift is held). The ring keeps at
// most RING_DEPTH-1 events and silently drops new ones when full. The
// front end classifies a request in the cycle it is accepted and hands
// it through a two-entry command queue, so req_chan.ready only drops while
// that queue is full. The back end walks a report through the event
// sequencer, one step per candidate event (each modifier bit, each previous
// slot, then each current slot), and serves a pop through a registered ring
// read, then the response register, waiting while rsp_chan is stalled.
// The ring needs no clearing after reset; its read and write pointers alone
// say which entries hold events.
module boot_keyboard_report_to_key_events_unit import bkre_pkg::*; #(
   parameter int RING_DEPTH     = 32,
   parameter int ROLLOVER_SLOTS = 6
) (
   input  logic          clock,
   input  logic          reset,
   bkre_stream_if.sink   req_chan,
   bkre_stream_if.source rsp_chan
);

   // front to queue
   logic            front_cmd_valid;
   cmd_type         front_cmd;
   logic            q_push_ready;

   // queue to back
   logic            q_head_valid;
   cmd_type         q_head;
   logic            back_deq;
   cmdq_status_type q_status;

   // request classification and report diff
   bkre_front #(
      .ROLLOVER_SLOTS(ROLLOVER_SLOTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_ready (q_push_ready),
      .cmd_valid (front_cmd_valid),
      .cmd       (front_cmd)
   );

   // decouples request intake from event generation
   bkre_cmd_queue u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_cmd_valid),
      .push_data  (front_cmd),
      .push_ready (q_push_ready),
      .head_valid (q_head_valid),
      .head_data  (q_head),
      .pop        (back_deq),
      .status     (q_status)
   );

   // event sequencer, ring and response register
   bkre_back #(
      .RING_DEPTH     (RING_DEPTH),
      .ROLLOVER_SLOTS (ROLLOVER_SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head       (q_head),
      .deq        (back_deq),
      .rsp_chan   (rsp_chan)
   );

   // an empty pop carries nothing but zeros
   `BKRE_ASSERT_IMPLIES(a_empty_pop_zero, clock, reset, rsp_chan.valid && !rsp_chan.payload.event_valid, rsp_chan.payload.key_code == 8'd0 && rsp_chan.payload.ascii_code == 7'd0 && rsp_chan.payload.event_modifiers == 8'd0 && !rsp_chan.payload.key_pressed, "empty pop with nonzero fields")

   // releases, modifiers and high keycodes never carry a character
   `BKRE_ASSERT_IMPLIES(a_no_char, clock, reset, rsp_chan.valid && (!rsp_chan.payload.key_pressed || rsp_chan.payload.key_code[7]), rsp_chan.payload.ascii_code == 7'd0, "character on an event that has none")

   // a pop or a full-length report always lands in the command queue
   `BKRE_ASSERT_NEXT(a_cmd_queued, clock, reset, req_chan.valid && req_chan.ready && (req_chan.payload.action == ACTION_POP || req_chan.payload.report_length >= MIN_REPORT_LEN), !q_status.empty, "accepted request lost before the queue")

endmodule
